>>> hdl/muscl_limited_face_reconstruction_core_macros.svh
// Assertion helpers for the MUSCL face reconstruction core.
`ifndef MUSCL_LIMITED_FACE_RECONSTRUCTION_CORE_MACROS_SVH
`define MUSCL_LIMITED_FACE_RECONSTRUCTION_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MLFR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MLFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MLFR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MLFR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/mlfr_pkg.sv
`timescale 1ns / 1ps
package mlfr_pkg;

  localparam int VAL_W    = 32;
  localparam int DIFF_W   = 34;
  localparam int MAG_W    = 33;
  localparam int KAPPA_W  = 18;
  localparam int RATIO_QW = 31;
  localparam int LANES    = 4;

  localparam logic CFG_KAPPA   = 1'b0;
  localparam logic CFG_LIMITER = 1'b1;

  localparam logic [1:0] LIM_NONE     = 2'd0;
  localparam logic [1:0] LIM_VANLEER  = 2'd1;
  localparam logic [1:0] LIM_MINMOD   = 2'd2;
  localparam logic [1:0] LIM_SUPERBEE = 2'd3;

  localparam logic signed [KAPPA_W-1:0] KAPPA_RESET = 18'sd21845;

  typedef struct packed {
    logic                     active;
    logic signed [VAL_W-1:0]  q0;
    logic signed [VAL_W-1:0]  q1;
    logic signed [DIFF_W-1:0] dm;
    logic signed [DIFF_W-1:0] dp;
    logic signed [DIFF_W-1:0] dq;
  } stencil_t;

  typedef struct packed {
    logic zero;
    logic neg;
    logic ovf;
  } rflag_t;

  typedef struct packed {
    stencil_t              st;
    rflag_t [LANES-1:0]    fl;
  } side1_t;

  typedef struct packed {
    stencil_t                    st;
    logic [LANES-1:0][VAL_W-1:0] r;
  } side2_t;

  typedef struct packed {
    logic             updated;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } result_t;

endpackage

>>> hdl/mlfr_div.sv
`timescale 1ns / 1ps
module mlfr_div #(
  parameter int LANES = 4,
  parameter int DW    = 33,
  parameter int QW    = 31,
  parameter int SW    = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][DW+QW-1:0]    num,
  input  logic [LANES-1:0][DW-1:0]       den,
  input  logic [SW-1:0]                  side_in,
  output logic                           out_valid,
  output logic [LANES-1:0][QW-1:0]       quo,
  output logic [SW-1:0]                  side_out
);

  // restoring long division, one quotient bit per stage; caller keeps num < den << QW
  logic                         vld  [QW+1];
  logic [LANES-1:0][DW-1:0]     rem  [QW+1];
  logic [LANES-1:0][QW-1:0]     low  [QW+1];
  logic [LANES-1:0][DW-1:0]     dsr  [QW+1];
  logic [SW-1:0]                side [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= num[l][DW+QW-1:QW];
        low[0][l] <= num[l][QW-1:0];
        dsr[0][l] <= den[l];
      end
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [LANES-1:0][DW:0]   t;
    logic [LANES-1:0]         qb;
    logic [LANES-1:0][DW-1:0] rn;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]  = {rem[k-1][l], low[k-1][l][QW-1]};
        qb[l] = (t[l] >= {1'b0, dsr[k-1][l]});
        rn[l] = qb[l] ? DW'(t[l] - {1'b0, dsr[k-1][l]}) : t[l][DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= rn[l];
          low[k][l] <= {low[k-1][l][QW-2:0], qb[l]};
          dsr[k][l] <= dsr[k-1][l];
        end
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = low[QW];
  assign side_out  = side[QW];

endmodule

>>> hdl/mlfr_tail.sv
`timescale 1ns / 1ps
module mlfr_tail
  import mlfr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  side2_t                             side,
  input  logic [LANES-1:0][FRAC_BITS:0]      vl,
  input  logic signed [KAPPA_W-1:0]          kappa,
  input  logic [1:0]                         mode,
  output logic                               out_valid,
  output result_t                            res
);

  localparam int PHI_W = FRAC_BITS + 2;
  localparam int WLW   = ((FRAC_BITS + 1 > KAPPA_W) ? FRAC_BITS + 1 : KAPPA_W) + 1;
  localparam int MW    = WLW + PHI_W + 1;
  localparam int WW    = MW - FRAC_BITS;
  localparam int PW    = WW + DIFF_W;
  localparam int SMW   = PW + 1;
  localparam int TW    = PW + 2;

  localparam logic signed [32:0]    ONE33 = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0]    TWO33 = 33'sd1 <<< (FRAC_BITS + 1);
  localparam logic signed [WLW-1:0] ONE_W = WLW'(1) <<< FRAC_BITS;
  localparam logic signed [TW-1:0]  MAXV  = TW'(32'sh7fffffff);
  localparam logic signed [TW-1:0]  MINV  = TW'(signed'(32'h80000000));

  // T1: limiter select
  logic                        v1, v2, v3, v4;
  stencil_t                    st1, st2, st3, st4;
  logic [LANES-1:0][PHI_W-1:0] phi, phi_next;

  always_comb begin
    logic signed [32:0] r, r2, a, b, m;
    for (int l = 0; l < LANES; l++) begin
      r  = 33'(signed'(side.r[l]));
      r2 = r <<< 1;
      a  = (r2 < ONE33) ? r2 : ONE33;
      b  = (r < TWO33) ? r : TWO33;
      m  = (b > a) ? b : a;
      unique case (mode)
        LIM_NONE:     phi_next[l] = PHI_W'(ONE33);
        LIM_VANLEER:  phi_next[l] = {1'b0, vl[l]};
        LIM_MINMOD: begin
          if (r <= 0)          phi_next[l] = '0;
          else if (r > ONE33)  phi_next[l] = PHI_W'(ONE33);
          else                 phi_next[l] = r[PHI_W-1:0];
        end
        LIM_SUPERBEE: phi_next[l] = (m > 0) ? m[PHI_W-1:0] : '0;
        default:      phi_next[l] = '0;
      endcase
    end
  end

  // T2: weights, lanes 0/2 use 1-kappa, lanes 1/3 use 1+kappa
  logic signed [WLW-1:0]      wl, wr;
  logic [LANES-1:0][WW-1:0]   w, w_next;

  assign wl = ONE_W - WLW'(kappa);
  assign wr = ONE_W + WLW'(kappa);

  always_comb begin
    logic signed [MW-1:0] prod;
    for (int l = 0; l < LANES; l++) begin
      prod = MW'(l[0] ? wr : wl) * MW'(signed'({1'b0, phi[l]}));
      w_next[l] = WW'(prod >>> FRAC_BITS);
    end
  end

  // T3: weight times difference
  logic [LANES-1:0][PW-1:0] p, p_next;

  always_comb begin
    logic signed [DIFF_W-1:0] d;
    for (int l = 0; l < LANES; l++) begin
      unique case (l)
        0:       d = st2.dm;
        2:       d = st2.dq;
        default: d = st2.dp;
      endcase
      p_next[l] = PW'(signed'(w[l])) * PW'(d);
    end
  end

  // T4: pair sums
  logic signed [SMW-1:0] s_l, s_r;

  // T5: shift, add to center, saturate
  logic signed [SMW-1:0] sh_l, sh_r;
  logic signed [TW-1:0]  tot_l, tot_r;
  logic [VAL_W-1:0]      left_next, right_next;

  assign sh_l  = s_l >>> (FRAC_BITS + 2);
  assign sh_r  = s_r >>> (FRAC_BITS + 2);
  assign tot_l = TW'(st4.q0) + TW'(sh_l);
  assign tot_r = TW'(st4.q1) - TW'(sh_r);

  always_comb begin
    if (tot_l > MAXV)      left_next = 32'h7fffffff;
    else if (tot_l < MINV) left_next = 32'h80000000;
    else                   left_next = tot_l[VAL_W-1:0];
    if (tot_r > MAXV)      right_next = 32'h7fffffff;
    else if (tot_r < MINV) right_next = 32'h80000000;
    else                   right_next = tot_r[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1         <= side.st;
      phi         <= phi_next;
      st2         <= st1;
      w           <= w_next;
      st3         <= st2;
      p           <= p_next;
      st4         <= st3;
      s_l         <= SMW'(signed'(p[0])) + SMW'(signed'(p[1]));
      s_r         <= SMW'(signed'(p[2])) + SMW'(signed'(p[3]));
      res.updated <= st4.active;
      res.left    <= st4.active ? left_next : '0;
      res.right   <= st4.active ? right_next : '0;
    end
  end

endmodule

>>> hdl/muscl_limited_face_reconstruction_core.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | value_behind..value_after_next, cell_active
// out     | output    | out_valid / out_stall| left_state, right_state, updated
// cfg     | input     | cfg_valid / cfg_ready| cfg_index (0 kappa, 1 limiter_mode), cfg_data
//
// One stencil per cycle sustained while out_stall holds no result; Q16.16 at FRAC_BITS=16.
// The path holds the 31-stage ratio divider and the FRAC_BITS+1 stage van Leer divider.
// Synchronous reset clears all valid bits and loads kappa = 21845, limiter = van Leer.
// A stalled result freezes the whole pipeline; in_stall follows out_stall while a
// result is held. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "muscl_limited_face_reconstruction_core_macros.svh"
module muscl_limited_face_reconstruction_core
  import mlfr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [VAL_W-1:0]    value_behind,
  input  logic signed [VAL_W-1:0]    value_here,
  input  logic signed [VAL_W-1:0]    value_next,
  input  logic signed [VAL_W-1:0]    value_after_next,
  input  logic                       cell_active,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VAL_W-1:0]    left_state,
  output logic signed [VAL_W-1:0]    right_state,
  output logic                       updated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [KAPPA_W-1:0]         cfg_data
);

  localparam int NW1 = MAG_W + RATIO_QW;
  localparam int QW2 = FRAC_BITS + 1;
  localparam int DW2 = VAL_W;
  localparam int NW2 = DW2 + QW2;
  localparam logic [VAL_W-1:0] ONE32 = VAL_W'(1) << FRAC_BITS;

  // lane order: phi1 = dp/dm, phi2 = dm/dp, phi3 = dp/dq, phi4 = dq/dp
  localparam int NUM_SEL [LANES] = '{1, 0, 1, 2};
  localparam int DEN_SEL [LANES] = '{0, 1, 2, 1};

  logic                      en;
  logic signed [KAPPA_W-1:0] kappa;
  logic [1:0]                limiter_mode;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kappa        <= KAPPA_RESET;
      limiter_mode <= LIM_VANLEER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KAPPA:   kappa        <= signed'(cfg_data);
        CFG_LIMITER: limiter_mode <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  // S1: biased differences
  logic     v1, v2;
  stencil_t st1, st2;
  logic [2:0][MAG_W-1:0] mag;
  logic [2:0]            sgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1.active <= cell_active;
      st1.q0     <= value_here;
      st1.q1     <= value_next;
      st1.dm     <= DIFF_W'(value_here) - DIFF_W'(value_behind) + DIFF_W'(1);
      st1.dp     <= DIFF_W'(value_next) - DIFF_W'(value_here) + DIFF_W'(1);
      st1.dq     <= DIFF_W'(value_after_next) - DIFF_W'(value_next) + DIFF_W'(1);
      // S2: magnitudes and signs
      st2    <= st1;
      mag[0] <= MAG_W'(st1.dm[DIFF_W-1] ? -st1.dm : st1.dm);
      mag[1] <= MAG_W'(st1.dp[DIFF_W-1] ? -st1.dp : st1.dp);
      mag[2] <= MAG_W'(st1.dq[DIFF_W-1] ? -st1.dq : st1.dq);
      sgn    <= {st1.dq[DIFF_W-1], st1.dp[DIFF_W-1], st1.dm[DIFF_W-1]};
    end
  end

  // ratio divider feed; overflow means |q| reaches 2^31 and saturates
  logic [LANES-1:0][NW1-1:0]   d1_num;
  logic [LANES-1:0][MAG_W-1:0] d1_den;
  side1_t                      d1_in, d1_out;
  logic                        d1_valid;
  logic [LANES-1:0][RATIO_QW-1:0] d1_quo;

  always_comb begin
    d1_in.st = st2;
    for (int l = 0; l < LANES; l++) begin
      d1_num[l]      = NW1'(mag[NUM_SEL[l]]) << FRAC_BITS;
      d1_den[l]      = mag[DEN_SEL[l]];
      d1_in.fl[l].zero = (mag[NUM_SEL[l]] == '0);
      d1_in.fl[l].neg  = sgn[NUM_SEL[l]] ^ sgn[DEN_SEL[l]];
      d1_in.fl[l].ovf  = (NW1'(mag[NUM_SEL[l]]) >=
                          (NW1'(mag[DEN_SEL[l]]) << (RATIO_QW - FRAC_BITS)));
    end
  end

  mlfr_div #(
    .LANES (LANES),
    .DW    (MAG_W),
    .QW    (RATIO_QW),
    .SW    ($bits(side1_t))
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .num       (d1_num),
    .den       (d1_den),
    .side_in   (d1_in),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .side_out  (d1_out)
  );

  // S4: signed, saturated ratios
  logic                         v4;
  side2_t                       s4;
  logic [LANES-1:0][VAL_W-1:0]  r_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (d1_out.fl[l].zero)
        r_next[l] = '0;
      else if (d1_out.fl[l].ovf)
        r_next[l] = d1_out.fl[l].neg ? 32'h80000000 : 32'h7fffffff;
      else if (d1_out.fl[l].neg)
        r_next[l] = -{1'b0, d1_quo[l]};
      else
        r_next[l] = {1'b0, d1_quo[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4.st <= d1_out.st;
      s4.r  <= r_next;
    end
  end

  // van Leer: (2r << F) / (1 + r) for r > 0, else zero
  logic [LANES-1:0][NW2-1:0] vl_num;
  logic [LANES-1:0][DW2-1:0] vl_den;
  logic                      d2_valid;
  side2_t                    d2_out;
  logic [LANES-1:0][QW2-1:0] d2_quo;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!s4.r[l][VAL_W-1] && (s4.r[l] != '0)) begin
        vl_num[l] = NW2'(s4.r[l][VAL_W-2:0]) << (FRAC_BITS + 1);
        vl_den[l] = ONE32 + s4.r[l];
      end else begin
        vl_num[l] = '0;
        vl_den[l] = ONE32;
      end
    end
  end

  mlfr_div #(
    .LANES (LANES),
    .DW    (DW2),
    .QW    (QW2),
    .SW    ($bits(side2_t))
  ) u_vl_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       (vl_num),
    .den       (vl_den),
    .side_in   (s4),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .side_out  (d2_out)
  );

  result_t res;

  mlfr_tail #(
    .FRAC_BITS (FRAC_BITS)
  ) u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d2_valid),
    .side      (d2_out),
    .vl        (d2_quo),
    .kappa     (kappa),
    .mode      (limiter_mode),
    .out_valid (out_valid),
    .res       (res)
  );

  assign left_state  = signed'(res.left);
  assign right_state = signed'(res.right);
  assign updated     = res.updated;

  `MLFR_ASSERT_IMPL(a_idle_face_zero, clk, rst, out_valid && !updated,
                    (left_state == '0) && (right_state == '0))
  `MLFR_ASSERT_IMPL(a_vl_den_nonzero, clk, rst, v4,
                    (vl_den[0] != '0) && (vl_den[1] != '0) &&
                    (vl_den[2] != '0) && (vl_den[3] != '0))
  `MLFR_ASSERT_NEXT(a_rst_clears_out, clk, 1'b0, rst, !out_valid && !v4)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mlfr_pkg::*;

  localparam int  FRAC = 16;
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_CYCLES = 120;
  localparam int  PHASE_ITEMS = 210;

  typedef struct {
    logic signed [VAL_W-1:0] behind;
    logic signed [VAL_W-1:0] here;
    logic signed [VAL_W-1:0] nxt;
    logic signed [VAL_W-1:0] after;
    logic                    active;
    bit                      typed;
    logic [VAL_W-1:0]        t_left;
    logic [VAL_W-1:0]        t_right;
    logic                    t_upd;
  } stencil_row_t;

  typedef struct {
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
    logic             upd;
  } face_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VAL_W-1:0] value_behind = '0;
  logic signed [VAL_W-1:0] value_here = '0;
  logic signed [VAL_W-1:0] value_next = '0;
  logic signed [VAL_W-1:0] value_after_next = '0;
  logic cell_active = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] left_state;
  logic signed [VAL_W-1:0] right_state;
  logic updated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_KAPPA;
  logic [KAPPA_W-1:0] cfg_data = '0;

  face_t  face_q[$];
  longint kappa_q;
  logic [1:0] lim_mode;
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 0;
  bit     long_hold = 0;

  muscl_limited_face_reconstruction_core #(.FRAC_BITS(FRAC)) dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic longint sat32(longint v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  function automatic longint slope_ratio(longint num, longint den);
    longint unsigned un, ud, q;
    bit neg;
    if (den == 0) return (num > 0) ? MAX32 : (num < 0) ? MIN32 : 0;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    q = (un << FRAC) / ud;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return sat32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint limited_slope(longint r);
    longint a, b;
    case (lim_mode)
      LIM_NONE: return ONE;
      LIM_VANLEER: begin
        if (r <= 0) return 0;
        return longint'((longint'(r) << (FRAC + 1)) / (ONE + r));
      end
      LIM_MINMOD: begin
        if (r <= 0) return 0;
        return (r > ONE) ? ONE : r;
      end
      default: begin
        a = (2 * r < ONE) ? 2 * r : ONE;
        b = (r < 2 * ONE) ? r : 2 * ONE;
        if (b > a) a = b;
        return (a > 0) ? a : 0;
      end
    endcase
  endfunction

  function automatic face_t reconstruct_faces(stencil_row_t s);
    face_t f;
    longint q0, q1, dm, dp, dq, wl, wr, acc;
    if (!s.active) begin
      f.left = '0; f.right = '0; f.upd = 1'b0;
      return f;
    end
    q0 = longint'(s.here);
    q1 = longint'(s.nxt);
    dm = q0 - longint'(s.behind) + 1;
    dp = q1 - q0 + 1;
    dq = longint'(s.after) - q1 + 1;
    wl = ONE - kappa_q;
    wr = ONE + kappa_q;
    acc = ((wl * limited_slope(slope_ratio(dp, dm))) >>> FRAC) * dm
        + ((wr * limited_slope(slope_ratio(dm, dp))) >>> FRAC) * dp;
    f.left = VAL_W'(sat32(q0 + (acc >>> (FRAC + 2))));
    acc = ((wl * limited_slope(slope_ratio(dp, dq))) >>> FRAC) * dq
        + ((wr * limited_slope(slope_ratio(dq, dp))) >>> FRAC) * dp;
    f.right = VAL_W'(sat32(q1 - (acc >>> (FRAC + 2))));
    f.upd = 1'b1;
    return f;
  endfunction

  // result checker
  always @(posedge clk) begin
    face_t e;
    if (!rst && out_valid && !out_stall) begin
      if (face_q.size() == 0) begin
        $display("%0t: unexpected beat left=%h right=%h updated=%b", $time,
                 left_state, right_state, updated);
        errors++;
      end else begin
        e = face_q.pop_front();
        if (left_state !== e.left) begin
          $display("%0t: left_state expected %h actual %h", $time, e.left, left_state);
          errors++;
        end
        if (right_state !== e.right) begin
          $display("%0t: right_state expected %h actual %h", $time, e.right, right_state);
          errors++;
        end
        if (updated !== e.upd) begin
          $display("%0t: updated expected %b actual %b", $time, e.upd, updated);
          errors++;
        end
      end
    end
  end

  // result side stall pattern
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      n = quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && !long_hold);
    end
  end

  task automatic send_stencil(stencil_row_t s);
    int n;
    face_t f;
    n = quiet ? 0 : $urandom_range(0, 5);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    value_behind <= s.behind;
    value_here <= s.here;
    value_next <= s.nxt;
    value_after_next <= s.after;
    cell_active <= s.active;
    do @(posedge clk); while (!(in_valid && !in_stall));
    f = reconstruct_faces(s);
    if (s.typed) begin
      f.left = s.t_left; f.right = s.t_right; f.upd = s.t_upd;
    end
    face_q.push_back(f);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (face_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [KAPPA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_KAPPA) kappa_q = longint'($signed(data));
    else lim_mode = data[1:0];
    @(posedge clk);
  endtask

  function automatic stencil_row_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                      logic [31:0] d, logic act);
    stencil_row_t s;
    s.behind = a; s.here = b; s.nxt = c; s.after = d; s.active = act;
    s.typed = 0; s.t_left = '0; s.t_right = '0; s.t_upd = 1'b0;
    return s;
  endfunction

  function automatic stencil_row_t mk_typed(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                            logic [31:0] d, logic act, logic [31:0] l,
                                            logic [31:0] r, logic u);
    stencil_row_t s;
    s = mk(a, b, c, d, act);
    s.typed = 1; s.t_left = l; s.t_right = r; s.t_upd = u;
    return s;
  endfunction

  function automatic stencil_row_t random_stencil();
    stencil_row_t s;
    logic [31:0] base;
    int kind;
    kind = $urandom_range(0, 9);
    base = $urandom();
    case (kind)
      0, 1: s = mk($urandom(), $urandom(), $urandom(), $urandom(), 1'b1);
      2: begin
        // zero differences: neighbors one LSB apart downward
        s = mk(base, base - 1, base - 2, $urandom_range(0, 1) ? base - 3 : $urandom(), 1'b1);
      end
      3: s = mk(base, base, base, base, 1'b1);
      4: s = mk($urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
      default: begin
        base = $urandom_range(0, 1) ? $urandom() : {{12{base[31]}}, base[19:0]};
        s = mk(base, base + $urandom_range(0, 400000) - 200000,
               base + $urandom_range(0, 400000) - 200000,
               base + $urandom_range(0, 400000) - 200000, 1'b1);
      end
    endcase
    return s;
  endfunction

  stencil_row_t directed[$];
  logic [KAPPA_W-1:0] kappa_set[8] = '{18'h30000, 18'h10000, 18'h00000, 18'h1FFFF,
                                       18'h20000, 18'h05555, 18'h3AAAB, 18'h08000};
  logic [1:0] mode_set[8] = '{LIM_NONE, LIM_VANLEER, LIM_MINMOD, LIM_SUPERBEE,
                              LIM_MINMOD, LIM_SUPERBEE, LIM_VANLEER, LIM_NONE};

  initial begin
    kappa_q = 21845;
    lim_mode = LIM_VANLEER;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk_typed(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                1'b0, 32'h0, 32'h0, 1'b0));
    directed.push_back(mk_typed(0, 0, 0, 0, 1'b1, 32'h0, 32'h0, 1'b1));
    directed.push_back(mk_typed(32'h10000, 32'h10000, 32'h10000, 32'h10000, 1'b1,
                                32'h10000, 32'h10000, 1'b1));
    directed.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1));
    directed.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1));
    directed.push_back(mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
    directed.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b1));
    directed.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
    directed.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
    // zero denominators, zero over zero
    directed.push_back(mk(5, 4, 3, 2, 1'b1));
    directed.push_back(mk(5, 4, 10, 9, 1'b1));
    directed.push_back(mk(0, 100000, 99999, 300000, 1'b1));
    // negative ratios and steep slopes
    directed.push_back(mk(0, 65536, 0, 65536, 1'b1));
    directed.push_back(mk(0, 10, 1000000, 1000010, 1'b1));
    directed.push_back(mk(0, 65536, 131072, 196608, 1'b1));
    directed.push_back(mk(-65536, 0, 65536, 262144, 1'b1));
    foreach (directed[i]) send_stencil(directed[i]);
    drain_pipe();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_KAPPA, kappa_set[p]);
      write_reg(CFG_LIMITER, KAPPA_W'(mode_set[p]));
      quiet = (p == 2) || (p == 5);
      if (p == 5) long_hold = 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_stencil(random_stencil());
        if (p == 3 && i == PHASE_ITEMS / 2) drain_pipe();
      end
      quiet = 0;
      drain_pipe();
    end

    // random settings, including the upper bits of the data word
    write_reg(CFG_KAPPA, KAPPA_W'($urandom()));
    write_reg(CFG_LIMITER, KAPPA_W'($urandom()));
    repeat (60) send_stencil(random_stencil());

    in_valid <= 1'b0;
    while (face_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
